FILE: rtl/core/robust_selection_cost_eval_defines.svh
// assertion macros for the robust selection cost evaluator
`ifndef ROBUST_SELECTION_COST_EVAL_DEFINES_SVH
`define ROBUST_SELECTION_COST_EVAL_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, reported by $error
`define RSCE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, reported by $error
`define RSCE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSCE_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg)
`define RSCE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

FILE: rtl/core/rsce_pkg.sv
// shared types and constants of the robust selection cost evaluator
package rsce_pkg;

    // field widths
    localparam int COST_W    = 16;
    localparam int INDEX_W   = 6;
    localparam int MODE_W    = 2;
    localparam int CNT_W     = 7;
    localparam int SUM_W     = 21;
    localparam int TOT_W     = 22;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int TREE_LEAVES = 64;

    // saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX   = 21'h1FFFFF;
    localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCEN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK = 1'd1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] item_index;
        logic [COST_W-1:0]  cost_value;
        logic               scenario_last;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] scenario_cost;
        logic [TOT_W-1:0] total_objective;
        logic             short_flag;
    } out_result_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic closes;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/rsce_ctrl.sv
// controller state machine: item transfer, tree wait and result load
module rsce_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rsce_pkg::dp_status_t  status,
    output rsce_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM1 = 3'd1;
    localparam logic [2:0] ST_SUM2 = 3'd2;
    localparam logic [2:0] ST_SUM3 = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // handshake and commands
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        cmd.accept = in_valid && in_ready;
        cmd.finish = (state_reg == ST_FIN) && status.out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && status.closes)
                begin
                    state_next = ST_SUM1;
                end
            end
            ST_SUM1: state_next = ST_SUM2;
            ST_SUM2: state_next = ST_SUM3;
            ST_SUM3: state_next = ST_FIN;
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/rsce_list.sv
// insertion chain of kept scenario costs and registered adder tree over them
module rsce_list
#(
    parameter int MAX_ITEMS = 64,
    parameter int ENTRY_W   = 16,
    parameter int LEN_W     = 7,
    parameter int IDX_W     = 6
)
(
    input  logic                     clk,
    input  logic                     ins_en,
    input  logic [ENTRY_W-1:0]       value,
    input  logic [LEN_W-1:0]         pos,
    input  logic [LEN_W-1:0]         sum_len,
    output logic                     hit,
    output logic [ENTRY_W+5:0]       sum
);

    localparam int PAD_N = 1 << IDX_W;
    localparam int L1_W  = ENTRY_W + 2;
    localparam int L2_W  = ENTRY_W + 4;
    localparam int L3_W  = ENTRY_W + 6;
    localparam int N1    = rsce_pkg::TREE_LEAVES / 4;
    localparam int N2    = rsce_pkg::TREE_LEAVES / 16;

    logic [ENTRY_W-1:0] cell_reg  [MAX_ITEMS];
    logic [ENTRY_W-1:0] cell_next [MAX_ITEMS];
    logic [PAD_N-1:0]   le_vec;
    logic [MAX_ITEMS-1:0] low_vec;
    logic [MAX_ITEMS-1:0] any_ge;
    logic [ENTRY_W-1:0] leaf [rsce_pkg::TREE_LEAVES];
    logic [L1_W-1:0]    lvl1_reg  [N1];
    logic [L1_W-1:0]    lvl1_next [N1];
    logic [L2_W-1:0]    lvl2_reg  [N2];
    logic [L2_W-1:0]    lvl2_next [N2];
    logic [L3_W-1:0]    lvl3_reg;
    logic [L3_W-1:0]    lvl3_next;

    genvar gi;

    // per-cell compare and the cells below the insert point
    always_comb
    begin
        le_vec = '0;
        for (int r = 0; r < MAX_ITEMS; r++)
        begin
            le_vec[r]  = (cell_reg[r] <= value);
            low_vec[r] = le_vec[r] && (LEN_W'(r) < pos);
        end
        for (int r = 0; r < MAX_ITEMS; r++)
        begin
            any_ge[r] = |(low_vec & ({MAX_ITEMS{1'b1}} << r));
        end
    end

    // the last kept value is not above the new one
    assign hit = le_vec[pos[IDX_W-1:0]];

    // each cell shifts up, takes the new value or holds
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                always_comb
                begin
                    cell_next[gi] = cell_reg[gi];
                    if (!any_ge[gi])
                    begin
                        cell_next[gi] = value;
                    end
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    cell_next[gi] = cell_reg[gi];
                    if (LEN_W'(gi) <= pos)
                    begin
                        if (!any_ge[gi-1])
                        begin
                            cell_next[gi] = cell_reg[gi-1];
                        end
                        else if (!any_ge[gi])
                        begin
                            cell_next[gi] = value;
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            cell_reg <= cell_next;
        end
    end

    // tree leaves: kept prefix only, zero above
    generate
        for (gi = 0; gi < rsce_pkg::TREE_LEAVES; gi++)
        begin : g_leaf
            if (gi < MAX_ITEMS)
            begin : g_used
                assign leaf[gi] = (LEN_W'(gi) < sum_len) ? cell_reg[gi] : '0;
            end
            else
            begin : g_pad
                assign leaf[gi] = '0;
            end
        end
    endgenerate

    // three registered levels of four-input adders
    always_comb
    begin
        for (int i = 0; i < N1; i++)
        begin
            lvl1_next[i] = L1_W'(leaf[4*i]) + L1_W'(leaf[4*i+1])
                         + L1_W'(leaf[4*i+2]) + L1_W'(leaf[4*i+3]);
        end
        for (int i = 0; i < N2; i++)
        begin
            lvl2_next[i] = L2_W'(lvl1_reg[4*i]) + L2_W'(lvl1_reg[4*i+1])
                         + L2_W'(lvl1_reg[4*i+2]) + L2_W'(lvl1_reg[4*i+3]);
        end
        lvl3_next = L3_W'(lvl2_reg[0]) + L3_W'(lvl2_reg[1])
                  + L3_W'(lvl2_reg[2]) + L3_W'(lvl2_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        lvl1_reg <= lvl1_next;
        lvl2_reg <= lvl2_next;
        lvl3_reg <= lvl3_next;
    end

    assign sum = lvl3_reg;

endmodule

FILE: rtl/core/rsce_dp.sv
// datapath: configuration, accumulators, kept list and result register
module rsce_dp
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [rsce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsce_pkg::MASK_W-1:0]          cfg_data,
    input  rsce_pkg::in_item_t                   in_item,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output rsce_pkg::out_result_t                out_result,
    input  rsce_pkg::ctrl_cmd_t                  cmd,
    output rsce_pkg::dp_status_t                 status
);

    localparam int ENTRY_W = (VALUE_BITS < rsce_pkg::COST_W) ? VALUE_BITS : rsce_pkg::COST_W;
    localparam int LEN_W   = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W   = rsce_pkg::CNT_W;
    localparam int SUM_W   = rsce_pkg::SUM_W;
    localparam int TOT_W   = rsce_pkg::TOT_W;
    localparam int MASK_W  = rsce_pkg::MASK_W;
    localparam logic [MASK_W-1:0] ITEM_MASK =
        (MAX_ITEMS >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << MAX_ITEMS) - MASK_W'(1));

    // popcount as a balanced tree of pairwise sums
    function automatic logic [CNT_W-1:0] count_ones(input logic [MASK_W-1:0] bits);
        logic [CNT_W-1:0] part [MASK_W];
        for (int i = 0; i < MASK_W; i++)
        begin
            part[i] = CNT_W'(bits[i]);
        end
        for (int step = 1; step < MASK_W; step = step * 2)
        begin
            for (int i = 0; i + step < MASK_W; i = i + 2 * step)
            begin
                part[i] = part[i] + part[i+step];
            end
        end
        return part[0];
    endfunction

    logic [MASK_W-1:0]  mask_reg,      mask_next;
    logic [CNT_W-1:0]   pick_reg,      pick_next;
    logic [CNT_W-1:0]   sel_cnt_reg,   sel_cnt_next;
    logic [SUM_W-1:0]   first_sum_reg, first_sum_next;
    logic [SUM_W-1:0]   worst_reg,     worst_next;
    logic [CNT_W-1:0]   kept_cnt_reg,  kept_cnt_next;
    logic [LEN_W-1:0]   kept_len_reg,  kept_len_next;
    logic               out_valid_reg, out_valid_next;
    rsce_pkg::out_result_t out_result_reg, out_result_next;

    logic [CNT_W-1:0]   fill;
    logic [LEN_W-1:0]   cap;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   pos;
    logic [LEN_W-1:0]   new_len;
    logic               full;
    logic               item_ok;
    logic               selected;
    logic [ENTRY_W-1:0] value;
    logic               cand;
    logic               ins_en;
    logic               hit;
    logic [ENTRY_W+5:0] tree_sum;
    logic [TOT_W-1:0]   tree_wide;
    logic [TOT_W-1:0]   first_add;
    logic [SUM_W-1:0]   scen;
    logic [SUM_W-1:0]   worst_upd;

    // fill count, list cap and current list length
    always_comb
    begin
        fill = (pick_reg > sel_cnt_reg) ? (pick_reg - sel_cnt_reg) : '0;
        cap  = (fill > CNT_W'(MAX_ITEMS)) ? LEN_W'(MAX_ITEMS) : LEN_W'(fill);
        len  = (kept_cnt_reg < CNT_W'(cap)) ? LEN_W'(kept_cnt_reg) : cap;
        full = (len == cap);
        pos  = full ? (len - LEN_W'(1)) : len;
        new_len = full ? len : (len + LEN_W'(1));
    end

    // item decode
    always_comb
    begin
        item_ok  = CNT_W'(in_item.item_index) < CNT_W'(MAX_ITEMS);
        selected = item_ok && mask_reg[in_item.item_index];
        value    = in_item.cost_value[ENTRY_W-1:0];
        cand     = cmd.accept && (in_item.mode == rsce_pkg::MODE_SCEN) && item_ok && !selected;
        ins_en   = cand && (cap != '0) && !(full && hit);
    end

    rsce_list
    #(
        .MAX_ITEMS (MAX_ITEMS),
        .ENTRY_W   (ENTRY_W),
        .LEN_W     (LEN_W),
        .IDX_W     (IDX_W)
    )
    u_list
    (
        .clk     (clk),
        .ins_en  (ins_en),
        .value   (value),
        .pos     (pos),
        .sum_len (kept_len_reg),
        .hit     (hit),
        .sum     (tree_sum)
    );

    // scenario cost and worst case at the end of a scenario
    always_comb
    begin
        tree_wide = TOT_W'(tree_sum);
        if (cap == '0)
        begin
            scen = '0;
        end
        else if (tree_wide > TOT_W'(rsce_pkg::SUM_MAX))
        begin
            scen = rsce_pkg::SUM_MAX;
        end
        else
        begin
            scen = tree_wide[SUM_W-1:0];
        end
        worst_upd = (scen > worst_reg) ? scen : worst_reg;
        first_add = TOT_W'(first_sum_reg) + TOT_W'(value);
    end

    // state updates
    always_comb
    begin
        mask_next       = mask_reg;
        pick_next       = pick_reg;
        sel_cnt_next    = sel_cnt_reg;
        first_sum_next  = first_sum_reg;
        worst_next      = worst_reg;
        kept_cnt_next   = kept_cnt_reg;
        kept_len_next   = kept_len_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_result_next = out_result_reg;

        // configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                rsce_pkg::CFG_MASK:
                begin
                    mask_next    = cfg_data;
                    sel_cnt_next = count_ones(cfg_data & ITEM_MASK);
                end
                rsce_pkg::CFG_PICK:
                begin
                    pick_next = cfg_data[CNT_W-1:0];
                end
                default:
                begin
                    pick_next = pick_reg;
                end
            endcase
        end

        // item transfer
        if (cmd.accept)
        begin
            case (in_item.mode)
                rsce_pkg::MODE_CLEAR:
                begin
                    first_sum_next = '0;
                    worst_next     = '0;
                    kept_cnt_next  = '0;
                    kept_len_next  = '0;
                end
                rsce_pkg::MODE_FIRST:
                begin
                    if (selected)
                    begin
                        first_sum_next = (first_add > TOT_W'(rsce_pkg::SUM_MAX))
                                       ? rsce_pkg::SUM_MAX : first_add[SUM_W-1:0];
                    end
                end
                rsce_pkg::MODE_SCEN:
                begin
                    if (cand && (kept_cnt_reg < rsce_pkg::COUNT_MAX))
                    begin
                        kept_cnt_next = kept_cnt_reg + CNT_W'(1);
                    end
                    if (ins_en)
                    begin
                        kept_len_next = new_len;
                    end
                end
                default:
                begin
                    kept_len_next = kept_len_reg;
                end
            endcase
        end

        // result load closes the scenario
        if (cmd.finish)
        begin
            worst_next                      = worst_upd;
            out_valid_next                  = 1'b1;
            out_result_next.scenario_cost   = scen;
            out_result_next.total_objective = TOT_W'(first_sum_reg) + TOT_W'(worst_upd);
            out_result_next.short_flag      = (kept_cnt_reg < fill);
            kept_cnt_next                   = '0;
            kept_len_next                   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            pick_reg      <= '0;
            sel_cnt_reg   <= '0;
            first_sum_reg <= '0;
            worst_reg     <= '0;
            kept_cnt_reg  <= '0;
            kept_len_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            pick_reg      <= pick_next;
            sel_cnt_reg   <= sel_cnt_next;
            first_sum_reg <= first_sum_next;
            worst_reg     <= worst_next;
            kept_cnt_reg  <= kept_cnt_next;
            kept_len_reg  <= kept_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

    // outputs and status
    assign out_valid       = out_valid_reg;
    assign out_result      = out_result_reg;
    assign status.closes   = (in_item.mode == rsce_pkg::MODE_SCEN) && in_item.scenario_last;
    assign status.out_free = !out_valid_reg || out_ready;

endmodule

FILE: rtl/core/robust_selection_cost_eval.sv
// top level of the robust selection cost evaluator
// Scores a first-stage selection against streamed cost scenarios. Mode 1 items add
// the costs of selected items; mode 2 items feed unselected costs into a sorted
// insertion chain that keeps the smallest (pick count minus selected count) of them,
// and the item flagged last closes the scenario with one result: the scenario sum,
// first-stage sum plus worst scenario sum, and a short flag. Items are taken only in
// the idle state; a closing item holds off input through the insert, three stages of
// the registered adder tree over the kept list and the result load, longer while the
// result register is still held by the sink. A finished result waits in the output
// register while new items are taken. Configuration is taken by a plain write port.
`include "robust_selection_cost_eval_defines.svh"

module robust_selection_cost_eval
#(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rsce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsce_pkg::MASK_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rsce_pkg::in_item_t                in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rsce_pkg::out_result_t             out_result
);

    rsce_pkg::ctrl_cmd_t  cmd;
    rsce_pkg::dp_status_t status;

    // sequencing
    rsce_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    rsce_dp
    #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (in_item),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_result (out_result),
        .cmd        (cmd),
        .status     (status)
    );

    // a closing transfer holds off further input while the tree runs
    `RSCE_ASSERT_NEXT(a_busy_after_close, clk, rst_n, cmd.accept && status.closes, !in_ready, "input taken during scenario sum")
    // a result is never loaded over one still waiting
    `RSCE_ASSERT_IMPL(a_finish_slot_free, clk, rst_n, cmd.finish, !out_valid || out_ready, "result register overwritten")
    // a loaded result is presented next cycle
    `RSCE_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_valid, "loaded result not presented")
    // no item transfer while a result is loaded
    `RSCE_ASSERT_IMPL(a_accept_finish_excl, clk, rst_n, cmd.finish, !cmd.accept, "transfer during result load")

endmodule

FILE: tb/rsce_result_checker.sv
// result prediction and checking for the robust selection cost evaluator
module rsce_result_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rsce_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsce_pkg::MASK_W-1:0]    cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  rsce_pkg::in_item_t             in_item,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  rsce_pkg::out_result_t          out_result,
    output int                             mismatches,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_SLOTS   = 64;
    localparam int REPORT_LINES = 40;
    localparam int SUM_W        = rsce_pkg::SUM_W;
    localparam int CNT_W        = rsce_pkg::CNT_W;
    localparam int COST_W       = rsce_pkg::COST_W;
    localparam int MASK_W       = rsce_pkg::MASK_W;

    // own copy of the configuration and the accumulators
    logic [MASK_W-1:0] chosen_mask;
    logic [CNT_W-1:0]  pick_total;
    logic [SUM_W-1:0]  first_stage_sum;
    logic [SUM_W-1:0]  worst_sum;
    logic [SUM_W-1:0]  kept_total;
    logic [COST_W-1:0] cheapest [ITEM_SLOTS];
    int unsigned       kept_seen;

    // scenario results predicted but not yet transferred
    rsce_pkg::out_result_t results_due [$];
    rsce_pkg::out_result_t want;

    task automatic flag_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, rsce_pkg::SUM_MAX}) ? rsce_pkg::SUM_MAX : s[SUM_W-1:0];
    endfunction

    // sorted insertion into the ascending list of the smallest costs
    task automatic keep_cheapest(input logic [COST_W-1:0] v, input int unsigned cap);
        int unsigned len;
        int unsigned pos;
        int unsigned newlen;
        bit          take;
        len  = (kept_seen < cap) ? kept_seen : cap;
        take = 1'b0;
        if (cap != 0)
        begin
            if (len < cap)
            begin
                pos    = len;
                newlen = len + 1;
                take   = 1'b1;
            end
            else if (v < cheapest[len-1])
            begin
                pos    = len - 1;
                newlen = len;
                take   = 1'b1;
            end
        end
        if (take)
        begin
            while (pos > 0 && cheapest[pos-1] > v)
            begin
                cheapest[pos] = cheapest[pos-1];
                pos--;
            end
            cheapest[pos] = v;
            kept_total = '0;
            for (int r = 0; r < newlen; r++)
                kept_total = sat_sum(kept_total, SUM_W'(cheapest[r]));
        end
    endtask

    // advance the predicted state by one accepted item
    task automatic score_item(input rsce_pkg::in_item_t it);
        int unsigned           chosen;
        int unsigned           fill;
        int unsigned           cap;
        logic                  in_range;
        logic                  picked;
        logic [SUM_W-1:0]      scen;
        rsce_pkg::out_result_t res;
        in_range = (it.item_index < ITEM_SLOTS);
        picked   = in_range && chosen_mask[it.item_index];
        chosen   = $countones(chosen_mask);
        fill     = (pick_total > chosen) ? pick_total - chosen : 0;
        cap      = (fill > ITEM_SLOTS) ? ITEM_SLOTS : fill;
        case (it.mode)
            rsce_pkg::MODE_CLEAR:
            begin
                first_stage_sum = '0;
                worst_sum       = '0;
                kept_seen       = 0;
                kept_total      = '0;
            end
            rsce_pkg::MODE_FIRST:
            begin
                if (picked)
                    first_stage_sum = sat_sum(first_stage_sum, SUM_W'(it.cost_value));
            end
            rsce_pkg::MODE_SCEN:
            begin
                if (in_range && !picked)
                begin
                    keep_cheapest(it.cost_value, cap);
                    if (kept_seen < rsce_pkg::COUNT_MAX)
                        kept_seen++;
                end
                // closing item: emit the scenario result
                if (it.scenario_last)
                begin
                    scen = (cap == 0) ? '0 : kept_total;
                    if (scen > worst_sum)
                        worst_sum = scen;
                    res.scenario_cost   = scen;
                    res.total_objective = {1'b0, first_stage_sum} + {1'b0, worst_sum};
                    res.short_flag      = (kept_seen < fill);
                    results_due.insert(results_due.size(), res);
                    kept_seen  = 0;
                    kept_total = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // watch config writes and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chosen_mask     = '0;
            pick_total      = '0;
            first_stage_sum = '0;
            worst_sum       = '0;
            kept_total      = '0;
            kept_seen       = 0;
            for (int i = 0; i < ITEM_SLOTS; i++)
                cheapest[i] = '0;
            results_due.delete();
            mismatches      = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == rsce_pkg::CFG_MASK)
                    chosen_mask = cfg_data;
                else if (cfg_index == rsce_pkg::CFG_PICK)
                    pick_total = cfg_data[CNT_W-1:0];
            end
            // result transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("result transfer with no result expected");
                else
                begin
                    want = results_due.pop_front();
                    if (out_result.scenario_cost !== want.scenario_cost)
                        flag_mismatch($sformatf("scenario_cost got %0h want %0h",
                                                out_result.scenario_cost, want.scenario_cost));
                    if (out_result.total_objective !== want.total_objective)
                        flag_mismatch($sformatf("total_objective got %0h want %0h",
                                                out_result.total_objective,
                                                want.total_objective));
                    if (out_result.short_flag !== want.short_flag)
                        flag_mismatch($sformatf("short_flag got %0b want %0b",
                                                out_result.short_flag, want.short_flag));
                end
            end
            if (in_valid && in_ready)
                score_item(in_item);
        end
        pending = results_due.size();
    end

endmodule

FILE: tb/robust_selection_cost_eval_tb.sv
// stimulus and verdict for the robust selection cost evaluator
module robust_selection_cost_eval_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int SEG_ITEMS    = 14;
    localparam int SEGMENTS     = 4;
    localparam int PHASES       = 3;
    localparam int LIST_SLOTS   = 64;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int MODE_W       = rsce_pkg::MODE_W;
    localparam int INDEX_W      = rsce_pkg::INDEX_W;
    localparam int COST_W       = rsce_pkg::COST_W;
    localparam int CNT_W        = rsce_pkg::CNT_W;
    localparam int MASK_W       = rsce_pkg::MASK_W;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [rsce_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]              cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    rsce_pkg::in_item_t             in_item;
    logic                           out_valid;
    logic                           out_ready;
    rsce_pkg::out_result_t          out_result;
    int                             mismatches;
    int                             pending;

    // stimulus bookkeeping
    logic [MASK_W-1:0]    mask_now;
    logic [CNT_W-1:0]     pick_now;
    int                   open_unsel;
    int                   listed_depth;
    int                   send_idle;
    int                   recv_idle;

    robust_selection_cost_eval i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    rsce_result_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #CLK_HALF clk = ~clk;

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // length of the kept list for a given setting
    function automatic int list_cap(input logic [MASK_W-1:0] mask, input logic [CNT_W-1:0] pick);
        int chosen;
        int fill;
        chosen = $countones(mask);
        fill   = (pick > chosen) ? pick - chosen : 0;
        return (fill > LIST_SLOTS) ? LIST_SLOTS : fill;
    endfunction

    function automatic logic [COST_W-1:0] draw_cost(input bit heavy);
        int r;
        r = $urandom_range(99);
        if (heavy)
            return 16'hF000 | 16'($urandom_range(16'h0FFF));
        if (r < 20)
            return '1;
        if (r < 30)
            return '0;
        if (r < 45)
            return 16'($urandom_range(255));
        return 16'($urandom);
    endfunction

    function automatic logic [MASK_W-1:0] draw_mask();
        case ($urandom_range(4))
            0: return '0;
            1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: return {$urandom, $urandom};
            3: return {$urandom, $urandom} | {$urandom, $urandom};
            default: return '1;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] draw_pick(input logic [MASK_W-1:0] mask);
        int r;
        int p;
        r = $urandom_range(99);
        if (r < 10)
            return 7'($urandom_range(65, 127));
        if (r < 30)
            return 7'($urandom_range(0, 64));
        p = $countones(mask) + $urandom_range(0, 12);
        return 7'((p > 64) ? 64 : p);
    endfunction

    // one input transfer, with a random gap in front
    task automatic drive_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                              input logic [COST_W-1:0] cost, input logic is_last);
        rsce_pkg::in_item_t it;
        int                 cap;
        it.mode          = mode;
        it.item_index    = idx;
        it.cost_value    = cost;
        it.scenario_last = is_last;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // track how deep the kept list has ever been filled
        cap = list_cap(mask_now, pick_now);
        if (mode == rsce_pkg::MODE_CLEAR)
            open_unsel = 0;
        else if (mode == rsce_pkg::MODE_SCEN)
        begin
            if (!mask_now[idx])
            begin
                if (open_unsel < rsce_pkg::COUNT_MAX)
                    open_unsel++;
                if (((open_unsel < cap) ? open_unsel : cap) > listed_depth)
                    listed_depth = (open_unsel < cap) ? open_unsel : cap;
            end
            if (is_last)
                open_unsel = 0;
        end
    endtask

    // wait until every result is out and the block is quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // new setting while idle; an open scenario that would grow the list into
    // never written entries is closed first
    task automatic retune(input logic [MASK_W-1:0] mask, input logic [CNT_W-1:0] pick);
        int cap;
        cap = list_cap(mask, pick);
        if (((open_unsel < cap) ? open_unsel : cap) > listed_depth)
            drive_item(rsce_pkg::MODE_SCEN, 6'($urandom), draw_cost(1'b0), 1'b1);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= rsce_pkg::CFG_MASK;
        cfg_data  <= mask;
        @(posedge clk);
        cfg_index <= rsce_pkg::CFG_PICK;
        cfg_data  <= {{(MASK_W-CNT_W){1'b0}}, pick};
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        mask_now = mask;
        pick_now = pick;
    endtask

    // random traffic: mostly first-stage runs and scenarios, some noise
    task automatic run_segment(input int quota);
        int  done;
        int  r;
        int  len;
        int  flaw;
        bit  heavy;
        done = 0;
        while (done < quota)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                drive_item(rsce_pkg::MODE_CLEAR, 6'($urandom), 16'($urandom), 1'($urandom));
                done++;
            end
            else if (r < 14)
            begin
                drive_item(MODE_UNUSED, 6'($urandom), 16'($urandom), 1'($urandom));
                done++;
            end
            else if (r < 30)
            begin
                len   = ($urandom_range(9) == 0) ? $urandom_range(35, 45) : $urandom_range(1, 8);
                heavy = ($urandom_range(99) < 30);
                for (int k = 0; k < len; k++)
                    drive_item(rsce_pkg::MODE_FIRST, 6'($urandom), draw_cost(heavy),
                               1'($urandom));
                done += len;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 4)
                    len = $urandom_range(128, 150);
                else if (r < 14)
                    len = $urandom_range(30, 70);
                else
                    len = $urandom_range(1, 12);
                heavy = ($urandom_range(99) < 15);
                flaw  = $urandom_range(99);
                for (int k = 0; k < len; k++)
                begin
                    // broken scenario: a clear in the middle
                    if (flaw >= 95 && k == len / 2)
                    begin
                        drive_item(rsce_pkg::MODE_CLEAR, 6'($urandom), 16'($urandom),
                                   1'($urandom));
                        done++;
                    end
                    // broken scenario: no closing item
                    drive_item(rsce_pkg::MODE_SCEN, 6'($urandom), draw_cost(heavy),
                               (k == len - 1) && (flaw >= 5));
                end
                done += len;
            end
        end
    endtask

    initial
    begin
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  pick;
        int                g;
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= rsce_pkg::CFG_MASK;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_item      <= '0;
        mask_now     = '0;
        pick_now     = '0;
        open_unsel   = 0;
        listed_depth = 0;
        send_idle    = 27;
        recv_idle    = 58;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: items 1, 2 and 63 selected, fill of four
        retune(64'h8000_0000_0000_0006, 7'd7);
        drive_item(rsce_pkg::MODE_CLEAR, 6'd0,  16'h0000, 1'b0);
        drive_item(rsce_pkg::MODE_FIRST, 6'd1,  16'hFFFF, 1'b1);
        drive_item(rsce_pkg::MODE_FIRST, 6'd0,  16'h1234, 1'b0);
        drive_item(rsce_pkg::MODE_FIRST, 6'd63, 16'h0001, 1'b0);
        drive_item(MODE_UNUSED,          6'd63, 16'hFFFF, 1'b1);
        // more unselected costs than the fill keeps
        drive_item(rsce_pkg::MODE_SCEN,  6'd5,  16'h8000, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd2,  16'h0000, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd0,  16'hFFFF, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd62, 16'h0000, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd10, 16'h00FF, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd11, 16'h0100, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd63, 16'hFFFF, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd12, 16'h7FFF, 1'b1);
        // too few unselected costs
        drive_item(rsce_pkg::MODE_SCEN,  6'd3,  16'h5555, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd4,  16'hAAAA, 1'b1);
        // scenario closed by a selected item only
        drive_item(rsce_pkg::MODE_SCEN,  6'd1,  16'hFFFF, 1'b1);
        // clear in the middle of a scenario
        drive_item(rsce_pkg::MODE_SCEN,  6'd20, 16'hAAAA, 1'b0);
        drive_item(rsce_pkg::MODE_CLEAR, 6'd42, 16'h5555, 1'b1);
        drive_item(rsce_pkg::MODE_SCEN,  6'd21, 16'h0001, 1'b1);
        // more selected than picked: fill is zero
        retune('1, 7'd0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd7,  16'hFFFF, 1'b1);
        // setting changed inside an open scenario
        retune('0, 7'd2);
        drive_item(rsce_pkg::MODE_SCEN,  6'd8,  16'h3333, 1'b0);
        drive_item(rsce_pkg::MODE_SCEN,  6'd9,  16'h1111, 1'b0);
        retune('0, 7'd1);
        drive_item(rsce_pkg::MODE_SCEN,  6'd10, 16'h2222, 1'b1);

        // random phases: receiver mostly idle, sender mostly idle, then no idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_idle = (ph == 0) ? 27 : (ph == 1) ? 58 : 0;
            recv_idle = (ph == 0) ? 58 : (ph == 1) ? 27 : 0;
            for (int seg = 0; seg < SEGMENTS; seg++)
            begin
                g = ph * SEGMENTS + seg;
                case (g)
                    0: begin mask = '0; pick = 7'd64;  end
                    1: begin mask = '1; pick = 7'd64;  end
                    2: begin mask = '0; pick = 7'd127; end
                    3: begin mask = '0; pick = 7'd0;   end
                    4: begin mask = '1; pick = 7'd127; end
                    default:
                    begin
                        mask = draw_mask();
                        pick = draw_pick(mask);
                    end
                endcase
                retune(mask, pick);
                run_segment(SEG_ITEMS);
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rsce_pkg.sv
rtl/core/rsce_ctrl.sv
rtl/core/rsce_list.sv
rtl/core/rsce_dp.sv
rtl/core/robust_selection_cost_eval.sv
tb/rsce_result_checker.sv
tb/robust_selection_cost_eval_tb.sv
